### design/swm_pkg.sv
`default_nettype none

package swm_pkg;

  // Default build sizes.
  localparam int WINDOW_MAX_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 32;

  // Configuration port.
  localparam int APB_ADDR_W = 2;
  localparam int APB_DATA_W = 32;
  localparam int WSIZE_W    = 7;

  localparam logic [APB_ADDR_W-1:0] ADDR_WINDOW_SIZE = 2'd0;
  localparam logic [WSIZE_W-1:0]    WSIZE_RESET      = 7'd3;

  // Broadcast control seen by every cell of the sorted row.
  typedef struct packed {
    logic en;    // an item is accepted this cycle
    logic full;  // the window is full, so the leaving sample is removed
  } ctl_t;

endpackage

`default_nettype wire

### design/swm_ring.sv
`default_nettype none

module swm_ring
  import swm_pkg::*;
#(
  parameter int DEPTH = WINDOW_MAX_DEF,
  parameter int W     = SAMPLE_WIDTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  logic signed [W-1:0] wdata,
  input  logic [AW-1:0]       raddr,
  output logic signed [W-1:0] rdata
);

  logic signed [W-1:0] mem [DEPTH];
  logic signed [W-1:0] rd_q;
  logic signed [W-1:0] wd_q;
  logic                byp;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
    wd_q <= wdata;
  end

  // A read of the address being written returns the new data.
  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else begin
      byp <= we && (waddr == raddr);
    end
  end

  assign rdata = byp ? wd_q : rd_q;

endmodule

`default_nettype wire

### design/swm_cell.sv
`default_nettype none

module swm_cell
  import swm_pkg::*;
#(
  parameter int W     = SAMPLE_WIDTH_DEF,
  parameter int CNT_W = 7,
  parameter int IDX   = 0
) (
  input  logic                clk,
  input  ctl_t                ctl,
  input  logic signed [W-1:0] sample,
  input  logic signed [W-1:0] leaving,
  input  logic [CNT_W-1:0]    limit,
  input  logic signed [W-1:0] r_val,
  input  logic                r_gtx,
  input  logic signed [W-1:0] l_tval,
  input  logic                l_gt,
  output logic signed [W-1:0] val,
  output logic                gtx,
  output logic signed [W-1:0] tval,
  output logic                gt
);

  logic ge;
  logic shift_in;
  logic past_limit;
  logic signed [W-1:0] val_next;

  // Entries at or right of the removed one close the gap from the right.
  assign ge         = val >= leaving;
  assign gtx        = val > sample;
  assign shift_in   = ctl.full && ge;
  assign tval       = shift_in ? r_val : val;
  assign past_limit = CNT_W'(IDX) >= limit;
  assign gt         = past_limit || (shift_in ? r_gtx : gtx);

  // Keep, take the new sample at the first greater slot, or shift right.
  assign val_next = !gt ? tval : (!l_gt ? sample : l_tval);

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      val <= val_next;
    end
  end

endmodule

`default_nettype wire

### design/sliding_window_median_top.sv
`default_nettype none

// Sliding-window median filter. Each accepted item carries one signed sample;
// once window_size samples have been seen, every item yields the median of the
// most recent window_size samples times two (one fraction bit): twice the middle
// entry for an odd window, the sum of the two middle entries for an even one.
// The block takes one item per clock cycle unless a pending result is blocked
// from the output register. The rate is set by the sorted row of cells: for
// each accepted item every cell compares its entry with the leaving and the new
// sample and takes its next entry from itself, a neighbor or the new sample. The
// leaving sample is prefetched from the sample ring memory, so its registered
// read never stalls the stream. A result is held as pending, then moved into an
// output register, so one further item can enter while a result waits to be
// taken. A write to window_size (allowed only while the block is idle) restarts
// the fill; the first window_size - 1 items after it, or after reset, give no
// result. Window sizes of zero act as one, sizes above WINDOW_MAX act as
// WINDOW_MAX. There is no clearing pass after reset.
module sliding_window_median_top
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_ADDR_W-1:0]        paddr,
  input  logic [APB_DATA_W-1:0]        pwdata,
  output logic [APB_DATA_W-1:0]        prdata,
  output logic                         pready,
  input  logic                         sample_valid,
  output logic                         sample_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic signed [SAMPLE_WIDTH:0] median_doubled
);

  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int W     = SAMPLE_WIDTH;

  // Configuration register and window bookkeeping.
  logic [WSIZE_W-1:0] window_size;
  logic [CNT_W-1:0]   fill;
  logic [CNT_W-1:0]   fill_next;
  logic [IDX_W-1:0]   oldest;
  logic [IDX_W-1:0]   oldest_next;
  logic [CNT_W-1:0]   k;
  logic [CNT_W-1:0]   limit;
  logic [CNT_W-1:0]   oldest_inc;
  logic               full;
  logic               cfg_wr;

  // Handshake and result staging.
  logic acc;
  logic produces;
  logic pend;
  logic pend_next;
  logic load;

  logic                 ring_we;
  logic [IDX_W-1:0]     ring_waddr;
  logic signed [W-1:0]  leaving;
  ctl_t                 ctl;

  logic signed [W-1:0]  vals  [WINDOW_MAX];
  logic signed [W-1:0]  tvals [WINDOW_MAX];
  logic                 gtxs  [WINDOW_MAX];
  logic                 gts   [WINDOW_MAX];

  logic [IDX_W-1:0]     mid_hi;
  logic [IDX_W-1:0]     mid_lo;
  logic signed [W:0]    med_sum;

  // The APB port: always ready, one register at byte address zero. Other
  // addresses read as zero and ignore writes.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_WINDOW_SIZE);
  assign prdata = (paddr == ADDR_WINDOW_SIZE) ? APB_DATA_W'(window_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WSIZE_RESET;
    end else if (cfg_wr) begin
      window_size <= pwdata[WSIZE_W-1:0];
    end
  end

  // Effective window length, clamped to 1..WINDOW_MAX.
  always_comb begin
    if (window_size == '0) begin
      k = CNT_W'(1);
    end else if (32'(window_size) > 32'(WINDOW_MAX)) begin
      k = CNT_W'(WINDOW_MAX);
    end else begin
      k = CNT_W'(window_size);
    end
  end

  assign full = (fill == k);

  // The sorted row only moves when an item is accepted. An item may enter
  // while the previous result waits, as long as that result can move into the
  // output register this cycle.
  assign load         = pend && (!result_valid || result_ready);
  assign sample_ready = !pend || load;
  assign acc          = sample_valid && sample_ready;

  assign oldest_inc = CNT_W'(oldest) + CNT_W'(1);

  always_comb begin
    fill_next   = fill;
    oldest_next = oldest;
    produces    = 1'b0;
    ring_we     = 1'b0;
    ring_waddr  = oldest;
    if (cfg_wr) begin
      fill_next   = '0;
      oldest_next = '0;
    end else if (acc) begin
      ring_we  = 1'b1;
      produces = 1'b1;
      if (!full) begin
        ring_waddr = IDX_W'(fill);
        fill_next  = fill + CNT_W'(1);
        produces   = (fill + CNT_W'(1)) == k;
      end else if (oldest_inc >= k) begin
        oldest_next = '0;
      end else begin
        oldest_next = IDX_W'(oldest_inc);
      end
    end
  end

  assign pend_next = acc ? produces : (load ? 1'b0 : pend);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill         <= '0;
      oldest       <= '0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      fill   <= fill_next;
      oldest <= oldest_next;
      pend   <= pend_next;
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Samples in arrival order. The read port always fetches the entry that will
  // leave on the next full-window item.
  swm_ring #(
    .DEPTH (WINDOW_MAX),
    .W     (W),
    .AW    (IDX_W)
  ) u_ring (
    .clk   (clk),
    .rst   (rst),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (sample),
    .raddr (oldest_next),
    .rdata (leaving)
  );

  // Row of sorted cells. While filling, the new sample is inserted among the
  // first fill entries; once full, the leaving sample is removed from the first
  // k entries and the new one inserted among the remaining k - 1.
  assign ctl.en   = acc;
  assign ctl.full = full;
  assign limit    = full ? (k - CNT_W'(1)) : fill;

  for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
    logic signed [W-1:0] r_val;
    logic                r_gtx;
    logic signed [W-1:0] l_tval;
    logic                l_gt;

    if (j == WINDOW_MAX - 1) begin : g_right_end
      assign r_val = '0;
      assign r_gtx = 1'b1;
    end else begin : g_right
      assign r_val = vals[j+1];
      assign r_gtx = gtxs[j+1];
    end

    if (j == 0) begin : g_left_end
      assign l_tval = '0;
      assign l_gt   = 1'b0;
    end else begin : g_left
      assign l_tval = tvals[j-1];
      assign l_gt   = gts[j-1];
    end

    swm_cell #(
      .W     (W),
      .CNT_W (CNT_W),
      .IDX   (j)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .sample  (sample),
      .leaving (leaving),
      .limit   (limit),
      .r_val   (r_val),
      .r_gtx   (r_gtx),
      .l_tval  (l_tval),
      .l_gt    (l_gt),
      .val     (vals[j]),
      .gtx     (gtxs[j]),
      .tval    (tvals[j]),
      .gt      (gts[j])
    );
  end

  // The median is read from the cells when the pending result moves into the
  // output register, while the row may already take the next item.
  assign mid_hi  = IDX_W'(k >> 1);
  assign mid_lo  = k[0] ? mid_hi : (mid_hi - IDX_W'(1));
  assign med_sum = {vals[mid_lo][W-1], vals[mid_lo]} + {vals[mid_hi][W-1], vals[mid_hi]};

  always_ff @(posedge clk) begin
    if (load) begin
      median_doubled <= med_sum;
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill <= k)
    else $error("fill count exceeds the window length");

  a_oldest_bounded: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(oldest) < k)
    else $error("oldest slot outside the window");

  a_full_item_gives_result: assert property (@(posedge clk) disable iff (rst)
    acc && full && !cfg_wr |=> pend)
    else $error("full-window item did not produce a result");

  a_result_from_pending: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(pend))
    else $error("result shown without a pending median");
`endif

endmodule

`default_nettype wire

### tb/sv/median_checker.sv
`timescale 1ns / 100ps

// Watches both item channels and the register port, keeps its own copy of the
// window, and compares every result with the oldest predicted median.
module median_checker
  import swm_pkg::*;
(
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [APB_ADDR_W-1:0]             paddr,
  input  logic [APB_DATA_W-1:0]             pwdata,
  input  logic [APB_DATA_W-1:0]             prdata,
  input  logic                              pready,
  input  logic                              sample_valid,
  input  logic                              sample_ready,
  input  logic signed [SAMPLE_WIDTH_DEF-1:0] sample,
  input  logic                              result_valid,
  input  logic                              result_ready,
  input  logic signed [SAMPLE_WIDTH_DEF:0]   median_doubled,
  output int                                failures,
  output int                                pending
);

  localparam int WMAX = WINDOW_MAX_DEF;
  localparam int SW   = SAMPLE_WIDTH_DEF;

  typedef logic signed [SW-1:0] sample_t;
  typedef logic signed [SW:0]   median_t;

  sample_t            ring [WMAX];
  sample_t            sorted_row [WMAX];
  int                 fill;
  int                 oldest;
  logic [WSIZE_W-1:0] wsize;
  median_t            median_q [$];
  int                 fail_cnt = 0;
  int                 waiting = 0;

  assign failures = fail_cnt;
  assign pending  = waiting;

  function automatic int eff_window(input logic [WSIZE_W-1:0] ws);
    int k;
    k = int'(ws);
    if (k < 1) k = 1;
    if (k > WMAX) k = WMAX;
    return k;
  endfunction

  function automatic median_t widen(input sample_t s);
    return median_t'(s);
  endfunction

  task report(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%s", msg);
  endtask

  // Removes the first entry equal to v from the lowest n sorted entries.
  task sorted_drop(input int n, input sample_t v);
    int i;
    i = 0;
    while (i < n - 1 && sorted_row[i] != v) i++;
    while (i + 1 < n) begin
      sorted_row[i] = sorted_row[i + 1];
      i++;
    end
  endtask

  // Inserts v after every entry that is not greater than it.
  task sorted_add(input int n, input sample_t v);
    int i;
    i = n;
    while (i > 0 && sorted_row[i - 1] > v) begin
      sorted_row[i] = sorted_row[i - 1];
      i--;
    end
    sorted_row[i] = v;
  endtask

  task shift_in(input sample_t x);
    int      k;
    median_t m;
    k = eff_window(wsize);
    if (fill > k) fill = k;
    if (oldest >= k) oldest = 0;
    if (fill < k) begin
      ring[fill] = x;
      sorted_add(fill, x);
      fill++;
    end else begin
      sorted_drop(k, ring[oldest]);
      sorted_add(k - 1, x);
      ring[oldest] = x;
      oldest++;
      if (oldest >= k) oldest = 0;
    end
    if (fill == k) begin
      if (k % 2 == 1) m = widen(sorted_row[k / 2]) + widen(sorted_row[k / 2]);
      else m = widen(sorted_row[k / 2 - 1]) + widen(sorted_row[k / 2]);
      median_q.push_back(m);
    end
  endtask

  always @(posedge clk) begin : watch
    median_t want;
    if (rst) begin
      fill   = 0;
      oldest = 0;
      wsize  = WSIZE_RESET;
      median_q.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (median_q.size() == 0) begin
          report($sformatf("unexpected median %0d with nothing waiting", median_doubled));
        end else begin
          want = median_q.pop_front();
          if (median_doubled !== want)
            report($sformatf("median mismatch: expected %0d, got %0d", want, median_doubled));
        end
      end
      if (psel && penable && pready && paddr == ADDR_WINDOW_SIZE) begin
        if (pwrite) begin
          wsize  = pwdata[WSIZE_W-1:0];
          fill   = 0;
          oldest = 0;
        end else if (prdata !== APB_DATA_W'(wsize)) begin
          report($sformatf("window_size readback: expected %0d, got %0d", wsize, prdata));
        end
      end
      if (sample_valid && sample_ready) shift_in(sample);
    end
    waiting <= median_q.size();
  end

endmodule

### tb/sv/tb_sliding_window_median_top.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the sliding-window median filter. The checker
// beside the block does all prediction; this module only drives items,
// register writes and reads and the result handshake.
module tb_sliding_window_median_top;
  import swm_pkg::*;

  localparam int SW        = SAMPLE_WIDTH_DEF;
  localparam int RAND_ITEMS = 1150;
  localparam int CYCLE_LIMIT = 300000;
  // Cycles to let pass after the last expected median, so that items which
  // give no result have left the pipeline.
  localparam int SETTLE = 8;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = ADDR_WINDOW_SIZE;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  sample_valid = 1'b0;
  logic                  sample_ready;
  logic signed [SW-1:0]  sample = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  logic signed [SW:0]    median_doubled;

  int failures;
  int pending;
  int cycles = 0;
  int send_idle_pct = 6;
  int recv_idle_pct = 62;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sliding_window_median_top u_top (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .sample_valid   (sample_valid),
    .sample_ready   (sample_ready),
    .sample         (sample),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .median_doubled (median_doubled)
  );

  median_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .sample_valid   (sample_valid),
    .sample_ready   (sample_ready),
    .sample         (sample),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .median_doubled (median_doubled),
    .failures       (failures),
    .pending        (pending)
  );

  // The receiver stalls at random; one decision per falling edge, so the
  // ready line gets a single assignment in each time step.
  always @(negedge clk) begin
    result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Guard against a hang: a lost result or a stuck handshake ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL sliding_window_median_top");
      $finish;
    end
  end

  // Offers one item and holds it until the block takes it. Gaps with valid
  // low come first, at the sender's idle rate. Returns at the falling edge
  // after acceptance without touching valid, so the next item can follow
  // back to back.
  task automatic send_sample(input logic [SW-1:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= v;
    do @(posedge clk); while (!sample_ready);
    @(negedge clk);
  endtask

  // Lowers valid and waits until every predicted median has been taken.
  task automatic drain_medians();
    sample_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // One APB transfer: setup cycle, then access cycle until pready.
  task automatic apb_xfer(input logic wr, input logic [APB_DATA_W-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_WINDOW_SIZE;
    pwdata  <= d;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Changes the window only while the block is idle: all medians taken,
  // then the SETTLE wait for items still in flight that give none. The
  // upper data bits are random, since only the low seven are the register.
  // The value is read back afterwards and checked by the checker.
  task automatic set_window(input logic [WSIZE_W-1:0] ws);
    logic [APB_DATA_W-1:0] d;
    d = $urandom;
    d[WSIZE_W-1:0] = ws;
    drain_medians();
    repeat (SETTLE) @(negedge clk);
    apb_xfer(1'b1, d);
    apb_xfer(1'b0, '0);
  endtask

  // Mostly full-range samples, with the extremes and a narrow band near
  // zero mixed in so that equal samples meet often in the sorted row.
  function automatic logic [SW-1:0] pick_sample();
    logic [SW-1:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'h8000_0000;
      1: v = 32'h7FFF_FFFF;
      2, 3: v = $urandom_range(0, 6) - 3;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  initial begin : stimulus
    int                 sent;
    int                 phase_no;
    int                 n_items;
    int                 k_eff;
    logic [WSIZE_W-1:0] ws;

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. The reset window of three is read back, then filled:
    // the first two items give no median, and the extremes of the sample
    // range and runs of equal samples pass through the sorted row.
    apb_xfer(1'b0, '0);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h0000_0000);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'd5);
    send_sample(32'd5);
    send_sample(32'd5);
    send_sample(32'hFFFF_FFFF);

    // An even window: the median is the sum of the two middles, which
    // reaches both ends of the result range.
    set_window(7'd2);
    send_sample(32'h8000_0000);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'd1);
    send_sample(32'hFFFF_FFFE);

    // A window size of zero behaves as a window of one.
    set_window(7'd0);
    send_sample(32'd7);
    send_sample(32'hFFFF_FFF9);
    set_window(7'd1);
    send_sample(32'd123);

    // Random part in phases, each with its own window size. The first
    // phases force the largest legal size and the largest register value,
    // which acts as the largest legal size. The idle pattern changes by
    // thirds: sender rarely idle, then receiver rarely idle, then neither.
    sent     = 0;
    phase_no = 0;
    while (sent < RAND_ITEMS) begin
      if (sent < RAND_ITEMS / 3) begin
        send_idle_pct = 6;
        recv_idle_pct = 62;
      end else if (sent < 2 * RAND_ITEMS / 3) begin
        send_idle_pct = 62;
        recv_idle_pct = 6;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase_no)
        0: ws = 7'd64;
        1: ws = 7'd127;
        2: ws = 7'd1;
        default: begin
          case ($urandom_range(0, 9))
            0: ws = 7'd0;
            1: ws = 7'd64;
            2: ws = 7'($urandom_range(65, 127));
            default: ws = 7'($urandom_range(1, 12));
          endcase
        end
      endcase
      set_window(ws);
      k_eff = (ws == 0) ? 1 : ((int'(ws) > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : int'(ws));
      n_items = k_eff + $urandom_range(8, 2 * k_eff + 20);
      for (int i = 0; i < n_items; i++) begin
        // Now and then the sender holds off mid-phase until the block has
        // handed over every median it owes, then resumes the same window.
        if (i == n_items / 2 && phase_no % 4 == 1) drain_medians();
        send_sample(pick_sample());
        sent++;
      end
      phase_no++;
    end

    drain_medians();
    repeat (20) @(negedge clk);
    if (failures == 0) begin
      $display("PASS sliding_window_median_top");
    end else begin
      $display("FAIL sliding_window_median_top");
    end
    $finish;
  end

endmodule

### filelist.f
design/swm_pkg.sv
design/swm_ring.sv
design/swm_cell.sv
design/sliding_window_median_top.sv
tb/sv/median_checker.sv
tb/sv/tb_sliding_window_median_top.sv
